>>> design/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared widths and codes for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;
    localparam int FIELD_BITS  = 16;
    localparam int SCALAR_BITS = 16;
    localparam int CNT_BITS    = $clog2(FIELD_BITS + 2);

    typedef logic [FIELD_BITS-1:0] fe_t;

    // arithmetic unit operations
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_INV = 2'd1;
    localparam logic [1:0] OP_RED = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        fe_t        u;
        fe_t        v;
        fe_t        p;
    } au_req_t;

    typedef struct packed {
        logic done;
        fe_t  res;
    } au_rsp_t;

    // field add and subtract, operands below p
    function automatic fe_t fadd(fe_t u, fe_t v, fe_t p);
        fe_t pv;
        pv = p - v;
        return (u >= pv) ? fe_t'(u - pv) : fe_t'(u + v);
    endfunction

    function automatic fe_t fsub(fe_t u, fe_t v, fe_t p);
        return (u >= v) ? fe_t'(u - v) : fe_t'(u + (p - v));
    endfunction
endpackage

>>> design/ec_scalar_multiply_prime_field_top.sv
// ----------------------------------------------------------------------------
// ec_scalar_multiply_prime_field_top
// Scalar times affine point by right-to-left double-and-add over GF(p).
//
// channel  | signals                              | direction
// command  | start, scalar, point_x/y; busy out   | in
// result   | done, result_x, result_y, at_infinity| out
// config   | psel/penable/pwrite/paddr/pwdata     | in, prdata/pready out
//
// Each point step runs up to five multiplies and one inverse in the single
// shared unit; a modulus below 3 goes straight to the result beat. Busy is
// high from acceptance until done pulses. The result beat lasts one cycle;
// the receiver cannot stall. Reset restores p = 97, a = 2.
// ----------------------------------------------------------------------------
module ec_scalar_multiply_prime_field_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] scalar,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    output logic        done,
    output logic [15:0] result_x,
    output logic [15:0] result_y,
    output logic        at_infinity,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int FB = ecsm_pkg::FIELD_BITS;
    localparam logic [2:0] ADDR_PRIME = 3'd0;
    localparam logic [2:0] ADDR_A     = 3'd4;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RA    = 5'd1;
    localparam logic [4:0] S_RX    = 5'd2;
    localparam logic [4:0] S_RY    = 5'd3;
    localparam logic [4:0] S_BIT   = 5'd4;
    localparam logic [4:0] S_ADD0  = 5'd5;   // add: inverse of dx
    localparam logic [4:0] S_ADD1  = 5'd6;   // s = dy * inv
    localparam logic [4:0] S_DBL0  = 5'd7;   // x*x
    localparam logic [4:0] S_DBL1  = 5'd8;   // 3 * xx
    localparam logic [4:0] S_DBL2  = 5'd9;   // inverse of 2y
    localparam logic [4:0] S_DBL3  = 5'd10;  // s = num * inv
    localparam logic [4:0] S_FIN0  = 5'd11;  // s*s
    localparam logic [4:0] S_FIN1  = 5'd12;  // s*(x1-x3)
    localparam logic [4:0] S_NEXT  = 5'd13;
    localparam logic [4:0] S_OUT   = 5'd14;
    localparam logic [4:0] S_WAIT  = 5'd15;

    logic [4:0]              state_reg, ret_reg;
    ecsm_pkg::fe_t           prime_reg, a_reg;
    ecsm_pkg::fe_t           p_reg, ca_reg;
    logic [ecsm_pkg::SCALAR_BITS-1:0] k_reg;
    ecsm_pkg::fe_t           ax_reg, ay_reg, rx_reg, ry_reg;
    ecsm_pkg::fe_t           t_reg, s_reg, x3_reg;
    logic                    dst_acc_reg;   // result goes to accumulator
    ecsm_pkg::fe_t           x1_reg, y1_reg, x2_reg;
    logic                    done_reg;
    ecsm_pkg::au_req_t       req;
    ecsm_pkg::au_rsp_t       rsp;
    logic                    wr;

    ecsm_arith u_arith (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign wr      = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_A) ? {16'd0, a_reg} :
                     (paddr == ADDR_PRIME) ? {16'd0, prime_reg} : 32'd0;
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign at_infinity = (result_x == '0) && (result_y == '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= ecsm_pkg::fe_t'(97);
            a_reg     <= ecsm_pkg::fe_t'(2);
        end
        else if (wr)
        begin
            if (paddr == ADDR_PRIME)
                prime_reg <= pwdata[FB-1:0];
            else if (paddr == ADDR_A)
                a_reg <= pwdata[FB-1:0];
        end
    end

    // issue a unit request
    always_comb
    begin
        req.start = 1'b0;
        req.op    = ecsm_pkg::OP_MUL;
        req.u     = '0;
        req.v     = '0;
        req.p     = p_reg;
        case (state_reg)
            S_RA:   begin req.start = 1'b1; req.op = ecsm_pkg::OP_RED; req.u = ca_reg; end
            S_RX:   begin req.start = 1'b1; req.op = ecsm_pkg::OP_RED; req.u = rx_reg; end
            S_RY:   begin req.start = 1'b1; req.op = ecsm_pkg::OP_RED; req.u = ry_reg; end
            S_ADD0: begin req.start = 1'b1; req.op = ecsm_pkg::OP_INV;
                          req.v = ecsm_pkg::fsub(rx_reg, ax_reg, p_reg); end
            S_ADD1: begin req.start = 1'b1; req.u = ecsm_pkg::fsub(ry_reg, ay_reg, p_reg);
                          req.v = t_reg; end
            S_DBL0: begin req.start = 1'b1; req.u = x1_reg; req.v = x1_reg; end
            S_DBL1: begin req.start = 1'b1; req.u = t_reg;
                          req.v = (p_reg == ecsm_pkg::fe_t'(3)) ? '0 : ecsm_pkg::fe_t'(3); end
            S_DBL2: begin req.start = 1'b1; req.op = ecsm_pkg::OP_INV;
                          req.v = ecsm_pkg::fadd(y1_reg, y1_reg, p_reg); end
            S_DBL3: begin req.start = 1'b1; req.u = s_reg; req.v = t_reg; end
            S_FIN0: begin req.start = 1'b1; req.u = s_reg; req.v = s_reg; end
            S_FIN1: begin req.start = 1'b1; req.u = s_reg;
                          req.v = ecsm_pkg::fsub(x1_reg, x3_reg, p_reg); end
            default: ;
        endcase
    end

    // double-and-add sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        p_reg  <= prime_reg;
                        ca_reg <= a_reg;
                        k_reg  <= scalar;
                        rx_reg <= point_x;
                        ry_reg <= point_y;
                        ax_reg <= '0;
                        ay_reg <= '0;
                        state_reg <= (prime_reg < ecsm_pkg::fe_t'(3)) ? S_OUT : S_RA;
                    end
                end
                S_RA:   begin ret_reg <= S_RX; state_reg <= S_WAIT; end
                S_RX:   begin ret_reg <= S_RY; state_reg <= S_WAIT; end
                S_RY:   begin ret_reg <= S_BIT; state_reg <= S_WAIT; end
                S_WAIT:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= ret_reg;
                        case (ret_reg)
                            S_RX:   ca_reg <= rsp.res;
                            S_RY:   rx_reg <= rsp.res;
                            S_BIT:  ry_reg <= rsp.res;
                            S_ADD1: t_reg  <= rsp.res;
                            S_DBL1: t_reg  <= rsp.res;
                            S_DBL2: s_reg  <= ecsm_pkg::fadd(rsp.res, ca_reg, p_reg);
                            S_DBL3: t_reg  <= rsp.res;
                            S_FIN0: s_reg  <= rsp.res;
                            S_FIN1: x3_reg <= ecsm_pkg::fsub(ecsm_pkg::fsub(rsp.res,
                                              x1_reg, p_reg), x2_reg, p_reg);
                            S_NEXT:
                            begin
                                if (dst_acc_reg)
                                begin
                                    ax_reg <= x3_reg;
                                    ay_reg <= ecsm_pkg::fsub(rsp.res, y1_reg, p_reg);
                                end
                                else
                                begin
                                    rx_reg <= x3_reg;
                                    ry_reg <= ecsm_pkg::fsub(rsp.res, y1_reg, p_reg);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_BIT:
                begin
                    // pick the next point operation
                    if (k_reg == '0)
                        state_reg <= S_OUT;
                    else if (k_reg[0])
                    begin
                        k_reg[0]    <= 1'b0;
                        dst_acc_reg <= 1'b1;
                        x1_reg <= ax_reg; y1_reg <= ay_reg; x2_reg <= rx_reg;
                        if (rx_reg == '0 && ry_reg == '0)
                            state_reg <= S_BIT;
                        else if (ax_reg == '0 && ay_reg == '0)
                        begin
                            ax_reg <= rx_reg; ay_reg <= ry_reg; state_reg <= S_BIT;
                        end
                        else if (ax_reg == rx_reg)
                        begin
                            if (ay_reg == ry_reg && ay_reg != '0)
                            begin
                                x2_reg <= ax_reg; state_reg <= S_DBL0;
                            end
                            else
                            begin
                                ax_reg <= '0; ay_reg <= '0; state_reg <= S_BIT;
                            end
                        end
                        else
                            state_reg <= S_ADD0;
                    end
                    else
                    begin
                        k_reg       <= k_reg >> 1;
                        dst_acc_reg <= 1'b0;
                        x1_reg <= rx_reg; y1_reg <= ry_reg; x2_reg <= rx_reg;
                        if ((k_reg >> 1) == '0)
                            state_reg <= S_OUT;
                        else if (ry_reg == '0)
                        begin
                            rx_reg <= '0; ry_reg <= '0; state_reg <= S_BIT;
                        end
                        else
                            state_reg <= S_DBL0;
                    end
                end
                S_ADD0: begin ret_reg <= S_ADD1; state_reg <= S_WAIT; end
                S_ADD1: begin ret_reg <= S_FIN0; state_reg <= S_WAIT; end
                S_DBL0: begin ret_reg <= S_DBL1; state_reg <= S_WAIT; end
                S_DBL1: begin ret_reg <= S_DBL2; state_reg <= S_WAIT; end
                S_DBL2: begin ret_reg <= S_DBL3; state_reg <= S_WAIT; end
                S_DBL3: begin ret_reg <= S_FIN0; state_reg <= S_WAIT; end
                S_FIN0: begin ret_reg <= S_FIN1; state_reg <= S_WAIT; end
                S_FIN1: begin ret_reg <= S_NEXT; state_reg <= S_WAIT; end
                S_NEXT: state_reg <= S_BIT;
                S_OUT:
                begin
                    result_x  <= ax_reg;
                    result_y  <= ay_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the result beat ends the item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");
endmodule

>>> design/ecsm_arith.sv
// ----------------------------------------------------------------------------
// ecsm_arith
// Shared multi-cycle unit: modular multiply (shift and add), reduction
// (restoring division) and inverse (extended Euclid).
// ----------------------------------------------------------------------------
module ecsm_arith
(
    input  logic              clk,
    input  logic              rst_n,
    input  ecsm_pkg::au_req_t req,
    output ecsm_pkg::au_rsp_t rsp
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_IDIV = 3'd3;
    localparam logic [2:0] S_IUPD = 3'd4;
    localparam logic [2:0] S_QMUL = 3'd5;
    localparam int         FB     = ecsm_pkg::FIELD_BITS;

    logic [2:0]              state_reg;
    logic                    done_reg;
    ecsm_pkg::fe_t           res_reg;
    ecsm_pkg::fe_t           p_reg;
    ecsm_pkg::fe_t           mu_reg, mv_reg, acc_reg;
    ecsm_pkg::fe_t           r0_reg, r1_reg, t0_reg, t1_reg;
    ecsm_pkg::fe_t           quo_reg;
    logic [FB:0]             rem_reg;
    ecsm_pkg::fe_t           dvd_reg;
    ecsm_pkg::fe_t           dvs_reg;
    logic [ecsm_pkg::CNT_BITS-1:0] cnt_reg;
    logic [FB:0]             rem_sh;

    assign rem_sh = {rem_reg[FB-1:0], dvd_reg[FB-1]};
    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    // sequence one operation at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        p_reg <= req.p;
                        case (req.op)
                            ecsm_pkg::OP_MUL:
                            begin
                                mu_reg    <= req.u;
                                mv_reg    <= req.v;
                                acc_reg   <= '0;
                                state_reg <= S_MUL;
                            end
                            ecsm_pkg::OP_INV:
                            begin
                                r0_reg    <= req.p;
                                r1_reg    <= req.v;
                                t0_reg    <= '0;
                                t1_reg    <= ecsm_pkg::fe_t'(1);
                                state_reg <= S_IUPD;
                            end
                            default:
                            begin
                                dvd_reg   <= req.u;
                                dvs_reg   <= req.p;
                                rem_reg   <= '0;
                                cnt_reg   <= ecsm_pkg::CNT_BITS'(FB);
                                state_reg <= S_RED;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    // one multiplier bit per cycle
                    if (mv_reg == '0)
                    begin
                        res_reg   <= acc_reg;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (mv_reg[0])
                            acc_reg <= ecsm_pkg::fadd(acc_reg, mu_reg, p_reg);
                        mu_reg <= ecsm_pkg::fadd(mu_reg, mu_reg, p_reg);
                        mv_reg <= mv_reg >> 1;
                    end
                end
                S_RED, S_IDIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (cnt_reg == '0)
                    begin
                        if (state_reg == S_RED)
                        begin
                            res_reg   <= rem_reg[FB-1:0];
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            // q below p already since r0 <= p, q < p unless r1 = 1
                            mu_reg    <= (quo_reg >= p_reg) ? quo_reg - p_reg : quo_reg;
                            mv_reg    <= t1_reg;
                            acc_reg   <= '0;
                            state_reg <= S_QMUL;
                            r0_reg    <= r1_reg;
                            r1_reg    <= rem_reg[FB-1:0];
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        dvd_reg <= {dvd_reg[FB-2:0], 1'b0};
                        if (rem_sh >= {1'b0, dvs_reg})
                        begin
                            rem_reg <= rem_sh - {1'b0, dvs_reg};
                            quo_reg <= {quo_reg[FB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[FB-2:0], 1'b0};
                        end
                    end
                end
                S_QMUL:
                begin
                    // t1 <- t0 - q*t1
                    if (mv_reg == '0)
                    begin
                        t0_reg    <= t1_reg;
                        t1_reg    <= ecsm_pkg::fsub(t0_reg, acc_reg, p_reg);
                        state_reg <= S_IUPD;
                    end
                    else
                    begin
                        if (mv_reg[0])
                            acc_reg <= ecsm_pkg::fadd(acc_reg, mu_reg, p_reg);
                        mu_reg <= ecsm_pkg::fadd(mu_reg, mu_reg, p_reg);
                        mv_reg <= mv_reg >> 1;
                    end
                end
                S_IUPD:
                begin
                    if (r1_reg == '0)
                    begin
                        res_reg   <= (r0_reg == ecsm_pkg::fe_t'(1)) ? t0_reg : '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        dvd_reg   <= r0_reg;
                        dvs_reg   <= r1_reg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= ecsm_pkg::CNT_BITS'(FB);
                        state_reg <= S_IDIV;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> verif/tb_ec_scalar_multiply_prime_field_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ec_scalar_multiply_prime_field_top
// Self-checking bench for the elliptic-curve scalar multiplier. A clocked
// driver issues command beats from a queue, and a clocked monitor checks
// every result beat against a point multiplier written in the bench.
// Several field primes and curve coefficients are programmed over APB
// while the block is idle: the reset values, the extremes, a modulus
// below 3, and a modulus that is not prime.
// ----------------------------------------------------------------------------
module tb_ec_scalar_multiply_prime_field_top;
    typedef longint unsigned u64_t;

    localparam logic [2:0] REG_PRIME_ADDR = 3'd0;
    localparam logic [2:0] REG_CURVE_A_ADDR = 3'd4;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [15:0] k;
        logic [15:0] px;
        logic [15:0] py;
    } mult_cmd_t;

    typedef struct packed {
        logic [15:0] rx;
        logic [15:0] ry;
        logic        inf;
    } mult_res_t;

    typedef struct {
        u64_t x;
        u64_t y;
    } ec_pt_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] scalar;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        done;
    logic [15:0] result_x;
    logic [15:0] result_y;
    logic        at_infinity;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mult_cmd_t cmd_q[$];
    mult_res_t product_q[$];
    u64_t      mdl_prime;
    u64_t      mdl_curve_a;
    int        n_sent;
    int        n_checked;
    int        n_errors;
    int        n_phases;
    int        n_inf;
    int        stall_cnt;

    ec_scalar_multiply_prime_field_top u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .scalar      (scalar),
        .point_x     (point_x),
        .point_y     (point_y),
        .done        (done),
        .result_x    (result_x),
        .result_y    (result_y),
        .at_infinity (at_infinity),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Field and curve arithmetic
    // ------------------------------------------------------------------
    function automatic u64_t gf_add(u64_t u, u64_t v, u64_t p);
        return (u >= p - v) ? u - (p - v) : u + v;
    endfunction

    function automatic u64_t gf_sub(u64_t u, u64_t v, u64_t p);
        return (u >= v) ? u - v : u + (p - v);
    endfunction

    function automatic u64_t gf_mul(u64_t u, u64_t v, u64_t p);
        u64_t acc;
        acc = 0;
        while (v != 0) begin
            if (v[0])
                acc = gf_add(acc, u, p);
            u = gf_add(u, u, p);
            v = v >> 1;
        end
        return acc;
    endfunction

    // extended Euclid; no inverse gives 0
    function automatic u64_t gf_inv(u64_t v, u64_t p);
        u64_t r0, r1, t0, t1, q, nr, nt;
        r0 = p;
        r1 = v;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            nr = r0 - q * r1;
            nt = gf_sub(t0, gf_mul(q % p, t1, p), p);
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        return (r0 == 1) ? t0 : 0;
    endfunction

    function automatic ec_pt_t pt_from_slope(u64_t s, u64_t x1, u64_t x2, u64_t y1, u64_t p);
        ec_pt_t r;
        r.x = gf_sub(gf_sub(gf_mul(s, s, p), x1, p), x2, p);
        r.y = gf_sub(gf_mul(s, gf_sub(x1, r.x, p), p), y1, p);
        return r;
    endfunction

    function automatic ec_pt_t pt_double(ec_pt_t q, u64_t a, u64_t p);
        ec_pt_t inf;
        u64_t num, s;
        inf.x = 0;
        inf.y = 0;
        if ((q.x == 0 && q.y == 0) || q.y == 0)
            return inf;
        num = gf_add(gf_mul(3 % p, gf_mul(q.x, q.x, p), p), a, p);
        s = gf_mul(num, gf_inv(gf_add(q.y, q.y, p), p), p);
        return pt_from_slope(s, q.x, q.x, q.y, p);
    endfunction

    function automatic ec_pt_t pt_sum(ec_pt_t u, ec_pt_t v, u64_t a, u64_t p);
        ec_pt_t inf;
        u64_t s;
        inf.x = 0;
        inf.y = 0;
        if (u.x == 0 && u.y == 0)
            return v;
        if (v.x == 0 && v.y == 0)
            return u;
        if (u.x == v.x)
            return (u.y == v.y) ? pt_double(u, a, p) : inf;
        s = gf_mul(gf_sub(v.y, u.y, p), gf_inv(gf_sub(v.x, u.x, p), p), p);
        return pt_from_slope(s, u.x, v.x, u.y, p);
    endfunction

    // k times P by right-to-left double-and-add
    function automatic mult_res_t scalar_product(mult_cmd_t c);
        ec_pt_t acc, run;
        u64_t p, a, k;
        mult_res_t r;
        p = mdl_prime;
        k = u64_t'(c.k);
        acc.x = 0;
        acc.y = 0;
        if (p >= 3) begin
            a = mdl_curve_a % p;
            run.x = u64_t'(c.px) % p;
            run.y = u64_t'(c.py) % p;
            while (k != 0) begin
                if (k[0])
                    acc = pt_sum(acc, run, a, p);
                k = k >> 1;
                if (k != 0)
                    run = pt_double(run, a, p);
            end
        end
        r.rx = acc.x[15:0];
        r.ry = acc.y[15:0];
        r.inf = (acc.x == 0 && acc.y == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Command driver: hold a beat until accepted, idle at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic      take;
        logic      quiet;
        mult_cmd_t c;
        if (!rst_n)
        begin
            start   <= 1'b0;
            scalar  <= '0;
            point_x <= '0;
            point_y <= '0;
        end
        else
        begin
            take = start && !busy;
            if (take)
            begin
                c.k = scalar;
                c.px = point_x;
                c.py = point_y;
                product_q.push_back(scalar_product(c));
                n_sent++;
            end
            if (take || !start)
            begin
                quiet = (n_sent >= 60 && n_sent < 90);
                if (cmd_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 36))
                begin
                    c = cmd_q.pop_front();
                    scalar  <= c.k;
                    point_x <= c.px;
                    point_y <= c.py;
                    start   <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each done beat with the oldest product
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        mult_res_t e;
        if (rst_n && done)
        begin
            if (product_q.size() == 0)
            begin
                $display("%0t: unexpected result beat x=%0d y=%0d inf=%0b",
                         $time, result_x, result_y, at_infinity);
                n_errors++;
            end
            else
            begin
                e = product_q.pop_front();
                n_checked++;
                if (e.inf)
                    n_inf++;
                if (result_x !== e.rx)
                begin
                    $display("%0t: result_x expected %0d actual %0d", $time, e.rx, result_x);
                    n_errors++;
                end
                if (result_y !== e.ry)
                begin
                    $display("%0t: result_y expected %0d actual %0d", $time, e.ry, result_y);
                    n_errors++;
                end
                if (at_infinity !== e.inf)
                begin
                    $display("%0t: at_infinity expected %0b actual %0b",
                             $time, e.inf, at_infinity);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no beat on either side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, product_q.size());
            $display("ec_scalar_multiply_prime_field_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_PRIME_ADDR)
            mdl_prime = data[15:0];
        else
            mdl_curve_a = data[15:0];
    endtask

    // wait until every beat is out and every product is back
    task automatic drain();
        while (cmd_q.size() > 0 || start || product_q.size() > 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_cmd(input logic [15:0] k, input logic [15:0] x, input logic [15:0] y);
        mult_cmd_t c;
        c.k = k;
        c.px = x;
        c.py = y;
        cmd_q.push_back(c);
    endtask

    // mostly short scalars and coordinates below p, some full-range noise
    task automatic add_random(input int n);
        logic [15:0] k, x, y;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                k = 16'($urandom_range(0, 255));
            else if (sel < 93)
                k = 16'($urandom_range(0, 4095));
            else
                k = 16'($urandom);
            if (mdl_prime >= 1 && $urandom_range(0, 99) < 75)
            begin
                x = 16'($urandom_range(0, int'(mdl_prime) - 1));
                y = 16'($urandom_range(0, int'(mdl_prime) - 1));
            end
            else
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            add_cmd(k, x, y);
        end
    endtask

    task automatic run_phase(input logic [15:0] p, input logic [15:0] a, input int n);
        drain();
        reg_write(REG_PRIME_ADDR, {16'($urandom), p});
        reg_write(REG_CURVE_A_ADDR, {16'($urandom), a});
        n_phases++;
        add_random(n);
    endtask

    initial
    begin
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mdl_prime   = 97;
        mdl_curve_a = 2;
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        n_phases    = 1;
        n_inf       = 0;
        stall_cnt   = 0;
        @(posedge rst_n);

        // directed items at the reset curve
        add_cmd(16'd0, 16'd3, 16'd6);          // zero scalar
        add_cmd(16'd1, 16'd3, 16'd6);
        add_cmd(16'd2, 16'd3, 16'd6);
        add_cmd(16'hFFFF, 16'd3, 16'd6);
        add_cmd(16'h8000, 16'd17, 16'd10);
        add_cmd(16'd5, 16'd0, 16'd0);          // base point at infinity
        add_cmd(16'd2, 16'd5, 16'd0);          // doubling with y of zero
        add_cmd(16'd3, 16'd5, 16'd0);
        add_cmd(16'd3, 16'd97, 16'd97);        // both reduce to zero
        add_cmd(16'd7, 16'd100, 16'd200);      // coordinates above p
        add_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_cmd(16'h5555, 16'hAAAA, 16'h5555);
        add_cmd(16'hAAAA, 16'h5555, 16'hAAAA);
        add_cmd(16'd1, 16'd0, 16'd5);          // x of zero, finite point
        add_cmd(16'd6, 16'd96, 16'd1);
        add_cmd(16'd13, 16'd1, 16'd96);
        add_random(14);

        run_phase(16'd65521, 16'hFFFF, 14);    // largest prime, a not below p
        run_phase(16'd3, 16'd0, 14);           // smallest odd prime
        run_phase(16'd5, 16'd1, 14);           // tiny field, many collisions
        run_phase(16'd7, 16'd3, 12);
        run_phase(16'hFFFF, 16'd12345, 12);    // modulus not prime
        run_phase(16'd2, 16'd7, 8);            // modulus below 3
        run_phase(16'd0, 16'd0, 6);
        run_phase(16'd7919, 16'($urandom), 14);
        run_phase(16'd97, 16'd2, 10);

        drain();
        $display("covered %0d multiplies over %0d curve settings, %0d at infinity",
                 n_checked, n_phases, n_inf);
        if (n_errors == 0)
            $display("ec_scalar_multiply_prime_field_top regression: pass");
        else
            $display("ec_scalar_multiply_prime_field_top regression: fail");
        $finish;
    end
endmodule

>>> filelist.f
design/ecsm_pkg.sv
design/ecsm_arith.sv
design/ec_scalar_multiply_prime_field_top.sv
verif/tb_ec_scalar_multiply_prime_field_top.sv
